// ===== rtl/lats_pkg.sv =====
// ----------------------------------------------------------------------------
// lats_pkg
// Shared types and constants of the toroidal life automaton block.
// ----------------------------------------------------------------------------
package lats_pkg;

    localparam int OP_W    = 2;
    localparam int COORD_W = 6;
    localparam int SIZE_W  = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL_RD,
        ST_ADV_UP,
        ST_ADV_CUR,
        ST_ADV_ROW,
        ST_DONE
    } t_state;

endpackage

// ===== rtl/lats_in_if.sv =====
// ----------------------------------------------------------------------------
// lats_in_if
// Command channel: one operation with its cell coordinates and write value.
// ----------------------------------------------------------------------------
interface lats_in_if;

    logic                        valid;
    logic                        ready;
    logic [lats_pkg::OP_W-1:0]    op;
    logic [lats_pkg::COORD_W-1:0] row;
    logic [lats_pkg::COORD_W-1:0] col;
    logic                        cell_in;

    modport source (output valid, output op, output row, output col, output cell_in,
                    input ready);
    modport sink (input valid, input op, input row, input col, input cell_in,
                  output ready);

endinterface

// ===== rtl/lats_out_if.sv =====
// ----------------------------------------------------------------------------
// lats_out_if
// Result channel: the cell value of a read and the coordinate range flag.
// ----------------------------------------------------------------------------
interface lats_out_if;

    logic valid;
    logic ready;
    logic cell_out;
    logic out_of_range;

    modport source (output valid, output cell_out, output out_of_range, input ready);
    modport sink (input valid, input cell_out, input out_of_range, output ready);

endinterface

// ===== rtl/lats_ram.sv =====
// ----------------------------------------------------------------------------
// lats_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module lats_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lats_row_next.sv =====
// ----------------------------------------------------------------------------
// lats_row_next
// Next generation of one grid row from the rows above, at and below it.
// ----------------------------------------------------------------------------
module lats_row_next #(
    parameter int MAX_WIDTH = 64,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  logic [MAX_WIDTH-1:0] i_up,
    input  logic [MAX_WIDTH-1:0] i_cur,
    input  logic [MAX_WIDTH-1:0] i_dn,
    input  logic [WW-1:0]        i_width,
    output logic [MAX_WIDTH-1:0] o_row
);

    logic [CW-1:0] last_col;
    logic          up_last;
    logic          cur_last;
    logic          dn_last;

    always_comb begin
        last_col = CW'(i_width - WW'(1));
        up_last  = i_up[last_col];
        cur_last = i_cur[last_col];
        dn_last  = i_dn[last_col];
    end

    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_lane
        localparam int L = (c + MAX_WIDTH - 1) % MAX_WIDTH;
        localparam int R = (c + 1) % MAX_WIDTH;

        logic       up_l, up_r, cur_l, cur_r, dn_l, dn_r;
        logic [3:0] count;
        logic       nxt_cell;

        always_comb begin
            up_l  = (c == 0) ? up_last  : i_up[L];
            cur_l = (c == 0) ? cur_last : i_cur[L];
            dn_l  = (c == 0) ? dn_last  : i_dn[L];
            up_r  = (last_col == CW'(c)) ? i_up[0]  : i_up[R];
            cur_r = (last_col == CW'(c)) ? i_cur[0] : i_cur[R];
            dn_r  = (last_col == CW'(c)) ? i_dn[0]  : i_dn[R];
            count = 4'(up_l) + 4'(i_up[c]) + 4'(up_r) + 4'(cur_l) + 4'(cur_r)
                  + 4'(dn_l) + 4'(i_dn[c]) + 4'(dn_r);
            if (WW'(c) >= i_width) begin
                nxt_cell = i_cur[c];
            end else if (count == 4'd3) begin
                nxt_cell = 1'b1;
            end else if (count == 4'd2) begin
                nxt_cell = i_cur[c];
            end else begin
                nxt_cell = 1'b0;
            end
        end

        assign o_row[c] = nxt_cell;
    end

endmodule

// ===== rtl/life_automaton_torus_step_top.sv =====
// ----------------------------------------------------------------------------
// life_automaton_torus_step_top
// Conway life grid on a torus, stored one row per word in a synchronous RAM.
// ----------------------------------------------------------------------------
// An in-range cell write or read passes through ST_CELL_RD to ST_DONE; an
// out-of-range access or a no-op goes to ST_DONE directly; a generation step
// reads the last and first rows, then writes one RAM row per cycle up to the
// clamped grid height. Commands are taken one at a time, the next while a result
// waits. After reset the RAM is cleared one row per cycle, all MAX_HEIGHT rows,
// while no command is taken; configuration writes are always taken.
module life_automaton_torus_step_top #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lats_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lats_pkg::SIZE_W-1:0]      i_cfg_data,
    lats_in_if.sink                          i_in,
    lats_out_if.source                       o_out
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    lats_pkg::t_state r_state, n_state;
    logic [RW-1:0]                r_row, n_row;
    logic [lats_pkg::SIZE_W-1:0]  r_grid_width, r_grid_height;
    logic                         r_out_valid, n_out_valid;
    logic                         r_out_cell, n_out_cell;
    logic                         r_out_oor, n_out_oor;
    logic [lats_pkg::OP_W-1:0]    r_op, n_op;
    logic [CW-1:0]                r_col, n_col;
    logic                         r_val, n_val;
    logic                         r_cell, n_cell;
    logic                         r_oor, n_oor;
    logic [MAX_WIDTH-1:0]         r_up, n_up;
    logic [MAX_WIDTH-1:0]         r_cur, n_cur;
    logic [MAX_WIDTH-1:0]         r_row0, n_row0;

    logic [WW-1:0]        eff_w;
    logic [HW-1:0]        eff_h;
    logic [RW-1:0]        h_last;
    logic [RW-1:0]        row_p1;
    logic [RW-1:0]        row_p2;
    logic                 in_oor;
    logic                 ram_we;
    logic [RW-1:0]        ram_waddr;
    logic [MAX_WIDTH-1:0] ram_wdata;
    logic [RW-1:0]        ram_raddr;
    logic [MAX_WIDTH-1:0] ram_rdata;
    logic [MAX_WIDTH-1:0] row_dn;
    logic [MAX_WIDTH-1:0] row_new;
    logic [MAX_WIDTH-1:0] row_mod;

    always_comb begin
        if (r_grid_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_grid_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_grid_width);
        end
        if (r_grid_height == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_grid_height) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_grid_height);
        end
        h_last = RW'(eff_h - HW'(1));
        row_p1 = (r_row == h_last) ? '0 : RW'(r_row + RW'(1));
        row_p2 = (row_p1 == h_last) ? '0 : RW'(row_p1 + RW'(1));
        in_oor = (32'(i_in.row) >= 32'(eff_h)) || (32'(i_in.col) >= 32'(eff_w));
        row_dn = (r_row == h_last) ? r_row0 : ram_rdata;
        row_mod = ram_rdata;
        row_mod[r_col] = r_val;
    end

    lats_ram #(
        .WIDTH(MAX_WIDTH),
        .DEPTH(MAX_HEIGHT)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lats_row_next #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_row_next (
        .i_up    (r_up),
        .i_cur   (r_cur),
        .i_dn    (row_dn),
        .i_width (eff_w),
        .o_row   (row_new)
    );

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_cell  = r_out_cell;
        n_out_oor   = r_out_oor;
        n_op        = r_op;
        n_col       = r_col;
        n_val       = r_val;
        n_cell      = r_cell;
        n_oor       = r_oor;
        n_up        = r_up;
        n_cur       = r_cur;
        n_row0      = r_row0;
        ram_we      = 1'b0;
        ram_waddr   = r_row;
        ram_wdata   = row_new;
        ram_raddr   = r_row;
        i_in.ready  = 1'b0;

        case (r_state)
            lats_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (r_row == RW'(MAX_HEIGHT - 1)) begin
                    n_row   = '0;
                    n_state = lats_pkg::ST_IDLE;
                end else begin
                    n_row = RW'(r_row + RW'(1));
                end
            end
            lats_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                ram_raddr  = (i_in.op == lats_pkg::OP_ADVANCE) ? h_last : RW'(i_in.row);
                if (i_in.valid) begin
                    n_op   = i_in.op;
                    n_col  = CW'(i_in.col);
                    n_val  = i_in.cell_in;
                    n_cell = 1'b0;
                    n_oor  = 1'b0;
                    case (i_in.op)
                        lats_pkg::OP_WRITE, lats_pkg::OP_READ: begin
                            n_row = RW'(i_in.row);
                            if (in_oor) begin
                                n_oor   = 1'b1;
                                n_state = lats_pkg::ST_DONE;
                            end else begin
                                n_state = lats_pkg::ST_CELL_RD;
                            end
                        end
                        lats_pkg::OP_ADVANCE: begin
                            n_row   = '0;
                            n_state = lats_pkg::ST_ADV_UP;
                        end
                        default: begin
                            n_state = lats_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            lats_pkg::ST_CELL_RD: begin
                if (r_op == lats_pkg::OP_WRITE) begin
                    ram_we    = 1'b1;
                    ram_wdata = row_mod;
                end else begin
                    n_cell = ram_rdata[r_col];
                end
                n_state = lats_pkg::ST_DONE;
            end
            lats_pkg::ST_ADV_UP: begin
                n_up      = ram_rdata;
                ram_raddr = '0;
                n_state   = lats_pkg::ST_ADV_CUR;
            end
            lats_pkg::ST_ADV_CUR: begin
                n_cur     = ram_rdata;
                n_row0    = ram_rdata;
                ram_raddr = row_p1;
                n_state   = lats_pkg::ST_ADV_ROW;
            end
            lats_pkg::ST_ADV_ROW: begin
                ram_we    = 1'b1;
                ram_wdata = row_new;
                ram_raddr = row_p2;
                n_up      = r_cur;
                n_cur     = row_dn;
                if (r_row == h_last) begin
                    n_state = lats_pkg::ST_DONE;
                end else begin
                    n_row = row_p1;
                end
            end
            lats_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_cell  = r_cell;
                    n_out_oor   = r_oor;
                    n_state     = lats_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lats_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lats_pkg::ST_CLEAR;
            r_row         <= '0;
            r_out_valid   <= 1'b0;
            r_grid_width  <= lats_pkg::SIZE_RESET;
            r_grid_height <= lats_pkg::SIZE_RESET;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_idx == lats_pkg::CFG_GRID_WIDTH) begin
                r_grid_width <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == lats_pkg::CFG_GRID_HEIGHT) begin
                r_grid_height <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_cell <= n_out_cell;
        r_out_oor  <= n_out_oor;
        r_op       <= n_op;
        r_col      <= n_col;
        r_val      <= n_val;
        r_cell     <= n_cell;
        r_oor      <= n_oor;
        r_up       <= n_up;
        r_cur      <= n_cur;
        r_row0     <= n_row0;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.cell_out     = r_out_cell;
    assign o_out.out_of_range = r_out_oor;

endmodule

// ===== tb/tb_life_automaton_torus_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_life_automaton_torus_step_top
// Drives cell writes, reads and generation steps into the toroidal life grid
// over a range of grid sizes. A local copy of the grid predicts every result,
// and each result transfer is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_life_automaton_torus_step_top;

    localparam logic [lats_pkg::OP_W-1:0] OP_NOP = 2'd3;
    localparam int GRID_MAX   = 64;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 200;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [lats_pkg::OP_W-1:0]    op;
        logic [lats_pkg::COORD_W-1:0] row;
        logic [lats_pkg::COORD_W-1:0] col;
        logic                         cell_in;
    } t_life_cmd;

    typedef struct packed {
        logic cell_out;
        logic out_of_range;
    } t_life_res;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [lats_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [lats_pkg::SIZE_W-1:0]    i_cfg_data;

    lats_in_if  cmd_if ();
    lats_out_if res_if ();

    life_automaton_torus_step_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (cmd_if),
        .o_out      (res_if)
    );

    t_life_cmd pending_cmds[$];
    t_life_res awaited_results[$];

    logic [GRID_MAX-1:0]         life_rows [GRID_MAX];
    logic [lats_pkg::SIZE_W-1:0] width_reg;
    logic [lats_pkg::SIZE_W-1:0] height_reg;

    bit cmd_taken;
    bit steady;
    bit hold_req;
    bit hold_done;
    int stall_left;
    int quiet_cycles;
    int error_count;
    int mismatch_count;
    int result_count;
    int op_counts [4];
    int oor_count;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int eff_size(logic [lats_pkg::SIZE_W-1:0] v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    task automatic life_advance();
        logic [GRID_MAX-1:0] nxt [GRID_MAX];
        int w;
        int h;
        int n;
        w = eff_size(width_reg, GRID_MAX);
        h = eff_size(height_reg, GRID_MAX);
        nxt = life_rows;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) begin
                            n += life_rows[(r + h + dr) % h][(c + w + dc) % w];
                        end
                    end
                end
                if (n == 3) begin
                    nxt[r][c] = 1'b1;
                end else if (n < 2 || n > 3) begin
                    nxt[r][c] = 1'b0;
                end
            end
        end
        life_rows = nxt;
    endtask

    task automatic life_apply(input t_life_cmd cmd, output t_life_res res);
        int w;
        int h;
        w = eff_size(width_reg, GRID_MAX);
        h = eff_size(height_reg, GRID_MAX);
        res = '0;
        if (cmd.op == lats_pkg::OP_WRITE || cmd.op == lats_pkg::OP_READ) begin
            if (cmd.row >= h || cmd.col >= w) begin
                res.out_of_range = 1'b1;
            end else if (cmd.op == lats_pkg::OP_WRITE) begin
                life_rows[cmd.row][cmd.col] = cmd.cell_in;
            end else begin
                res.cell_out = life_rows[cmd.row][cmd.col];
            end
        end else if (cmd.op == lats_pkg::OP_ADVANCE) begin
            life_advance();
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_life_res got;
        t_life_res want;
        t_life_cmd cmd;
        bit moved;
        moved = 1'b0;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            moved = 1'b1;
            result_count++;
            got = '{cell_out: res_if.cell_out, out_of_range: res_if.out_of_range};
            if (awaited_results.size() == 0) begin
                error_count++;
                $display("Result with no pending prediction at %0t", $realtime);
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Mismatch at %0t: cell_out %b/%b out_of_range %b/%b (exp/act)",
                                 $realtime, want.cell_out, got.cell_out,
                                 want.out_of_range, got.out_of_range);
                    end
                end
            end
        end
        cmd_taken = i_rst_n && cmd_if.valid && cmd_if.ready;
        if (cmd_taken) begin
            moved = 1'b1;
            cmd = '{op: cmd_if.op, row: cmd_if.row, col: cmd_if.col, cell_in: cmd_if.cell_in};
            life_apply(cmd, want);
            awaited_results.push_back(want);
            op_counts[cmd.op]++;
            if (want.out_of_range) oor_count++;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end

    always @(negedge i_clk) begin : driver
        t_life_cmd nxt;
        if (!i_rst_n) begin
            cmd_if.valid   <= 1'b0;
            cmd_if.op      <= lats_pkg::OP_WRITE;
            cmd_if.row     <= '0;
            cmd_if.col     <= '0;
            cmd_if.cell_in <= 1'b0;
        end else if (!cmd_if.valid || cmd_taken) begin
            if (pending_cmds.size() > 0 && (steady || $urandom_range(0, 99) >= 6)) begin
                nxt = pending_cmds.pop_front();
                cmd_if.valid   <= 1'b1;
                cmd_if.op      <= nxt.op;
                cmd_if.row     <= nxt.row;
                cmd_if.col     <= nxt.col;
                cmd_if.cell_in <= nxt.cell_in;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (hold_req && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = HOLD_LEN;
        end
        if (stall_left > 0) begin
            stall_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= steady || ($urandom_range(0, 99) >= 6);
        end
    end

    task automatic add_cmd(logic [lats_pkg::OP_W-1:0] op, int row, int col, logic val);
        t_life_cmd cmd;
        cmd.op      = op;
        cmd.row     = row[lats_pkg::COORD_W-1:0];
        cmd.col     = col[lats_pkg::COORD_W-1:0];
        cmd.cell_in = val;
        pending_cmds.push_back(cmd);
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || cmd_if.valid || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_size(int w, int h);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = lats_pkg::CFG_GRID_WIDTH;
        i_cfg_data = w[lats_pkg::SIZE_W-1:0];
        @(negedge i_clk);
        i_cfg_idx  = lats_pkg::CFG_GRID_HEIGHT;
        i_cfg_data = h[lats_pkg::SIZE_W-1:0];
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        width_reg  = w[lats_pkg::SIZE_W-1:0];
        height_reg = h[lats_pkg::SIZE_W-1:0];
    endtask

    function automatic int pick_coord(int lim);
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, lim - 1);
        return $urandom_range(0, GRID_MAX - 1);
    endfunction

    task automatic random_burst(int count);
        int w;
        int h;
        int pick;
        w = eff_size(width_reg, GRID_MAX);
        h = eff_size(height_reg, GRID_MAX);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 42) begin
                add_cmd(lats_pkg::OP_WRITE, pick_coord(h), pick_coord(w),
                        $urandom_range(0, 99) < 60);
            end else if (pick < 58) begin
                add_cmd(lats_pkg::OP_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                        1'($urandom_range(0, 1)));
            end else if (pick < 96) begin
                add_cmd(lats_pkg::OP_READ, pick_coord(h), pick_coord(w),
                        1'($urandom_range(0, 1)));
            end else begin
                add_cmd(OP_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
                        1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin : watchdog
        @(posedge i_rst_n);
        while (quiet_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : sequencer
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = lats_pkg::CFG_GRID_WIDTH;
        i_cfg_data     = '0;
        width_reg      = lats_pkg::SIZE_RESET;
        height_reg     = lats_pkg::SIZE_RESET;
        for (int r = 0; r < GRID_MAX; r++) life_rows[r] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        set_size(64, 64);
        add_cmd(lats_pkg::OP_WRITE, 0, 0, 1'b1);
        add_cmd(lats_pkg::OP_WRITE, 63, 63, 1'b1);
        add_cmd(lats_pkg::OP_READ, 63, 63, 1'b0);
        add_cmd(lats_pkg::OP_READ, 0, 0, 1'b1);
        add_cmd(lats_pkg::OP_READ, 0, 63, 1'b0);
        add_cmd(OP_NOP, 63, 63, 1'b0);
        add_cmd(lats_pkg::OP_READ, 63, 63, 1'b0);
        add_cmd(lats_pkg::OP_WRITE, 0, 63, 1'b1);
        add_cmd(lats_pkg::OP_ADVANCE, 0, 0, 1'b0);
        add_cmd(lats_pkg::OP_READ, 0, 0, 1'b0);
        add_cmd(lats_pkg::OP_READ, 63, 0, 1'b0);
        add_cmd(lats_pkg::OP_READ, 0, 62, 1'b0);
        set_size(3, 3);
        add_cmd(lats_pkg::OP_WRITE, 2, 2, 1'b1);
        add_cmd(lats_pkg::OP_WRITE, 3, 0, 1'b1);
        add_cmd(lats_pkg::OP_READ, 0, 3, 1'b0);
        add_cmd(lats_pkg::OP_ADVANCE, 63, 63, 1'b1);
        add_cmd(lats_pkg::OP_READ, 1, 1, 1'b0);
        set_size(1, 1);
        add_cmd(lats_pkg::OP_WRITE, 0, 0, 1'b1);
        add_cmd(lats_pkg::OP_ADVANCE, 0, 0, 1'b0);
        add_cmd(lats_pkg::OP_READ, 0, 0, 1'b0);
        add_cmd(lats_pkg::OP_READ, 63, 63, 1'b0);
        set_size(0, 127);
        add_cmd(lats_pkg::OP_ADVANCE, 0, 0, 1'b0);
        add_cmd(lats_pkg::OP_READ, 63, 0, 1'b0);

        set_size(64, 64);
        hold_req = 1'b1;
        random_burst(14);
        set_size(7, 5);
        random_burst(12);
        steady = 1'b1;
        set_size(1, 1);
        random_burst(8);
        set_size(2, 2);
        random_burst(10);
        steady = 1'b0;
        set_size(1, 3);
        random_burst(10);
        set_size(3, 1);
        random_burst(10);
        set_size(0, 127);
        random_burst(8);
        set_size(65, 2);
        random_burst(10);
        set_size(8, 8);
        random_burst(12);
        set_size(64, 3);
        random_burst(10);
        set_size(13, 64);
        random_burst(12);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            error_count += awaited_results.size();
            $display("%0d predicted results never arrived", awaited_results.size());
        end
        $display("Covered %0d writes, %0d reads, %0d generation steps, %0d no-ops.",
                 op_counts[lats_pkg::OP_WRITE], op_counts[lats_pkg::OP_READ],
                 op_counts[lats_pkg::OP_ADVANCE], op_counts[OP_NOP]);
        $display("Checked %0d results, %0d outside the grid, %0d errors.",
                 result_count, oor_count, error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
